FILE: hw/rtl/iprcc_pkg.sv
// shared constants, types and command/status structs of the i/o port range conflict checker
package iprcc_pkg;

   localparam int MAX_PORTS    = 64;
   localparam int MAX_RESERVED = 16;

   localparam int PORT_AW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
   localparam int RES_AW  = (MAX_RESERVED > 1) ? $clog2(MAX_RESERVED) : 1;
   localparam int PORT_FW = $clog2(MAX_PORTS + 1);
   localparam int RES_FW  = $clog2(MAX_RESERVED + 1);
   localparam int SCAN_W  = (PORT_FW > RES_FW) ? PORT_FW : RES_FW;

   localparam int ADDR_W  = 32;
   localparam int END_W   = 33;
   localparam int COUNT_W = 20;
   localparam int MASK_W  = 32;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_CHECK = 1'b1;
   localparam logic KIND_RANGE      = 1'b0;
   localparam logic KIND_RESTRICTED = 1'b1;

   localparam logic [MASK_W-1:0] ALL_BITS = '1;

   typedef enum logic [3:0] {
      ST_IDLE      = 4'b0001,
      ST_RES_SCAN  = 4'b0010,
      ST_PORT_SCAN = 4'b0100,
      ST_FINISH    = 4'b1000
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_res;
      logic scan_port;
      logic restart;
      logic commit;
   } ctl_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage

FILE: hw/rtl/iprcc_req_if.sv
// request channel interface: valid/ready handshake with the port entry payload
interface iprcc_req_if;
   import iprcc_pkg::*;

   logic               valid;
   logic               ready;
   logic               command;
   logic               port_kind;
   logic [ADDR_W-1:0]  base_address;
   logic [COUNT_W-1:0] word_count;
   logic [MASK_W-1:0]  bit_mask;

   modport source (output valid, command, port_kind, base_address, word_count, bit_mask,
                   input ready);
   modport sink (input valid, command, port_kind, base_address, word_count, bit_mask,
                 output ready);
endinterface

FILE: hw/rtl/iprcc_rsp_if.sv
// response channel interface: valid/ready handshake with the conflict report
interface iprcc_rsp_if;
   logic       valid;
   logic       ready;
   logic       reserved_hit;
   logic [3:0] reserved_index;
   logic       port_hit;
   logic [5:0] port_index;
   logic [5:0] entry_index;
   logic       table_full;

   modport source (output valid, reserved_hit, reserved_index, port_hit, port_index,
                   entry_index, table_full, input ready);
   modport sink (input valid, reserved_hit, reserved_index, port_hit, port_index,
                 entry_index, table_full, output ready);
endinterface

FILE: hw/rtl/iprcc_ctrl.sv
// controller state machine: sequences capture, table scans and commit
module iprcc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_command,
   output logic              req_ready,
   output iprcc_pkg::ctl_type ctl,
   input  iprcc_pkg::sts_type sts
);
   import iprcc_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in = (req_command == CMD_CHECK) ? ST_RES_SCAN : ST_FINISH;
            end
         end
         ST_RES_SCAN: begin
            ctl.scan_res = 1'b1;
            if (sts.scan_done) begin
               ctl.restart = 1'b1;
               state_in = ST_PORT_SCAN;
            end
         end
         ST_PORT_SCAN: begin
            ctl.scan_port = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the output register before storing and reporting
            if (sts.out_free) begin
               ctl.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/iprcc_dp.sv
// datapath: item registers, both tables, scan compare stage and response register
module iprcc_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  iprcc_pkg::ctl_type              ctl,
   output iprcc_pkg::sts_type              sts,
   input  logic                            req_command,
   input  logic                            req_port_kind,
   input  logic [iprcc_pkg::ADDR_W-1:0]    req_base_address,
   input  logic [iprcc_pkg::COUNT_W-1:0]   req_word_count,
   input  logic [iprcc_pkg::MASK_W-1:0]    req_bit_mask,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_reserved_hit,
   output logic [3:0]                      rsp_reserved_index,
   output logic                            rsp_port_hit,
   output logic [5:0]                      rsp_port_index,
   output logic [5:0]                      rsp_entry_index,
   output logic                            rsp_table_full
);
   import iprcc_pkg::*;

   localparam int PORT_WORD_W = ADDR_W + END_W + MASK_W;
   localparam int RES_WORD_W  = ADDR_W + END_W;

   // tables
   logic [PORT_WORD_W-1:0] port_mem [MAX_PORTS];
   logic [RES_WORD_W-1:0]  res_mem  [MAX_RESERVED];

   logic [PORT_FW-1:0] port_fill_ff, port_fill_in;
   logic [RES_FW-1:0]  res_fill_ff, res_fill_in;

   // current item
   logic              item_cmd_ff;
   logic [ADDR_W-1:0] item_lo_ff;
   logic [END_W-1:0]  item_hi_ff;
   logic [MASK_W-1:0] item_owned_ff;
   logic [END_W-1:0]  hi_in;
   logic [MASK_W-1:0] owned_in;

   // scan pointer and compare stage
   logic [SCAN_W-1:0]      ptr_ff, ptr_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic                   cmp_port_ff;
   logic [SCAN_W-1:0]      cmp_idx_ff;
   logic [PORT_WORD_W-1:0] port_rd_ff;
   logic [RES_WORD_W-1:0]  res_rd_ff;
   logic                   rd_port, rd_res;

   logic [ADDR_W-1:0] cmp_start;
   logic [END_W-1:0]  cmp_end;
   logic [MASK_W-1:0] cmp_bits;
   logic              meet;

   logic              res_hit_ff;
   logic [RES_AW-1:0] res_idx_ff;
   logic              port_hit_ff;
   logic [PORT_AW-1:0] port_idx_ff;

   logic       rsp_valid_ff;
   logic       rsp_res_hit_ff;
   logic [3:0] rsp_res_idx_ff;
   logic       rsp_port_hit_ff;
   logic [5:0] rsp_port_idx_ff;
   logic [5:0] rsp_entry_ff;
   logic       rsp_full_ff;

   logic res_full, port_full;

   assign res_full  = (res_fill_ff == RES_FW'(MAX_RESERVED));
   assign port_full = (port_fill_ff == PORT_FW'(MAX_PORTS));

   always_comb begin
      if (req_command == CMD_CHECK && req_port_kind == KIND_RESTRICTED) begin
         hi_in    = {1'b0, req_base_address} + END_W'(4);
         owned_in = req_bit_mask;
      end else begin
         hi_in    = {1'b0, req_base_address} + END_W'({req_word_count, 2'b00});
         owned_in = ALL_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         item_cmd_ff   <= req_command;
         item_lo_ff    <= req_base_address;
         item_hi_ff    <= hi_in;
         item_owned_ff <= owned_in;
      end
   end

   // scan read issue
   assign rd_res  = ctl.scan_res && (ptr_ff < SCAN_W'(res_fill_ff));
   assign rd_port = ctl.scan_port && (ptr_ff < SCAN_W'(port_fill_ff));

   always_comb begin
      ptr_in       = ptr_ff;
      cmp_valid_in = rd_res || rd_port;
      if (ctl.capture || ctl.restart) begin
         ptr_in = '0;
      end else if (rd_res || rd_port) begin
         ptr_in = ptr_ff + SCAN_W'(1);
      end
   end

   assign sts.scan_done = !(rd_res || rd_port) && !cmp_valid_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff  <= ptr_ff;
      cmp_port_ff <= rd_port;
   end

   // table reads, registered
   always_ff @(posedge clock) begin
      if (rd_port) begin
         port_rd_ff <= port_mem[ptr_ff[PORT_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_res) begin
         res_rd_ff <= res_mem[ptr_ff[RES_AW-1:0]];
      end
   end

   // table writes
   always_ff @(posedge clock) begin
      if (ctl.commit && item_cmd_ff == CMD_CHECK && !port_full) begin
         port_mem[port_fill_ff[PORT_AW-1:0]] <= {item_lo_ff, item_hi_ff, item_owned_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit && item_cmd_ff == CMD_LOAD && !res_full) begin
         res_mem[res_fill_ff[RES_AW-1:0]] <= {item_lo_ff, item_hi_ff};
      end
   end

   // compare stage
   always_comb begin
      if (cmp_port_ff) begin
         cmp_start = port_rd_ff[PORT_WORD_W-1 -: ADDR_W];
         cmp_end   = port_rd_ff[MASK_W +: END_W];
         cmp_bits  = port_rd_ff[MASK_W-1:0];
      end else begin
         cmp_start = res_rd_ff[RES_WORD_W-1 -: ADDR_W];
         cmp_end   = res_rd_ff[END_W-1:0];
         cmp_bits  = ALL_BITS;
      end
      meet = !(({1'b0, cmp_start} >= item_hi_ff) || (cmp_end <= {1'b0, item_lo_ff}));
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         res_hit_ff  <= 1'b0;
         res_idx_ff  <= '0;
         port_hit_ff <= 1'b0;
         port_idx_ff <= '0;
      end else if (cmp_valid_ff) begin
         // keep the lowest index: scan runs upward, first hit wins
         if (cmp_port_ff) begin
            if (!port_hit_ff && meet && (cmp_bits & item_owned_ff) != '0) begin
               port_hit_ff <= 1'b1;
               port_idx_ff <= cmp_idx_ff[PORT_AW-1:0];
            end
         end else begin
            if (!res_hit_ff && meet) begin
               res_hit_ff <= 1'b1;
               res_idx_ff <= cmp_idx_ff[RES_AW-1:0];
            end
         end
      end
   end

   // fill counts
   always_comb begin
      port_fill_in = port_fill_ff;
      res_fill_in  = res_fill_ff;
      if (ctl.commit) begin
         if (item_cmd_ff == CMD_CHECK) begin
            if (!port_full) begin
               port_fill_in = port_fill_ff + PORT_FW'(1);
            end
         end else begin
            if (!res_full) begin
               res_fill_in = res_fill_ff + RES_FW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_fill_ff <= '0;
         res_fill_ff  <= '0;
      end else begin
         port_fill_ff <= port_fill_in;
         res_fill_ff  <= res_fill_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_res_hit_ff  <= res_hit_ff;
         rsp_res_idx_ff  <= 4'(res_idx_ff);
         rsp_port_hit_ff <= port_hit_ff;
         rsp_port_idx_ff <= 6'(port_idx_ff);
         if (item_cmd_ff == CMD_CHECK) begin
            rsp_full_ff  <= port_full;
            rsp_entry_ff <= port_full ? 6'd0 : 6'(port_fill_ff);
         end else begin
            rsp_full_ff  <= res_full;
            rsp_entry_ff <= res_full ? 6'd0 : 6'(res_fill_ff);
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reserved_hit   = rsp_res_hit_ff;
   assign rsp_reserved_index = rsp_res_idx_ff;
   assign rsp_port_hit       = rsp_port_hit_ff;
   assign rsp_port_index     = rsp_port_idx_ff;
   assign rsp_entry_index    = rsp_entry_ff;
   assign rsp_table_full     = rsp_full_ff;

endmodule

FILE: hw/rtl/io_port_range_conflict_checker.sv
// top level of the i/o port range conflict checker
// Usage:
//   req_chan carries one transaction per item. command 0 appends a reserved
//   range (base_address, word_count). command 1 checks a port entry, a range
//   of words (port_kind 0) or one restricted word with bit_mask (port_kind 1),
//   against all reserved ranges and all earlier ports, then stores it.
//   rsp_chan returns one transaction per item: hit flags, lowest conflicting
//   indices, the stored index and a table-full flag (entry dropped).
// Sequencing:
//   items are handled one at a time. A load goes straight to the commit
//   that stores it and registers its response. A check scans each table
//   through one read port with a registered compare stage, reserved ranges
//   first, then ports, and the commit follows the port scan.
// Reset:
//   reset empties both tables (fill counts to zero) and drops any pending
//   response; table contents are not cleared.
// Stall:
//   a finished response waits in the output register while the next item is
//   accepted and scanned; the block holds before storing it until rsp is taken.
module io_port_range_conflict_checker (
   input  logic       clock,
   input  logic       reset,
   iprcc_req_if.sink  req_chan,
   iprcc_rsp_if.source rsp_chan
);
   import iprcc_pkg::*;

   ctl_type ctl;
   sts_type sts;

   iprcc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .ctl         (ctl),
      .sts         (sts)
   );

   iprcc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_command        (req_chan.command),
      .req_port_kind      (req_chan.port_kind),
      .req_base_address   (req_chan.base_address),
      .req_word_count     (req_chan.word_count),
      .req_bit_mask       (req_chan.bit_mask),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_reserved_hit   (rsp_chan.reserved_hit),
      .rsp_reserved_index (rsp_chan.reserved_index),
      .rsp_port_hit       (rsp_chan.port_hit),
      .rsp_port_index     (rsp_chan.port_index),
      .rsp_entry_index    (rsp_chan.entry_index),
      .rsp_table_full     (rsp_chan.table_full)
   );

endmodule
